[hdl/directory_open_rate_tracker_macros.svh]
// Assertion macros used by the directory open rate tracker top level.
`ifndef DIRECTORY_OPEN_RATE_TRACKER_MACROS_SVH
`define DIRECTORY_OPEN_RATE_TRACKER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define DORT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("directory_open_rate_tracker: assertion failed");

// Plain condition checked at every rising clock edge outside reset.
`define DORT_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("directory_open_rate_tracker: assertion failed");

`endif

[hdl/dort_pkg.sv]
// Package with types and constants of the directory open rate tracker.
`timescale 1ns / 1ps
package dort_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PREP   = 2'd1,
        PH_CACHED = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        OC_UNKNOWN  = 4'd0,
        OC_FEW      = 4'd1,
        OC_SIZE     = 4'd2,
        OC_TOO_NEW  = 4'd3,
        OC_INSERTED = 4'd4,
        OC_PREPARE  = 4'd5,
        OC_COUNTING = 4'd6,
        OC_IDLE     = 4'd7,
        OC_CACHED   = 4'd8,
        OC_REARMED  = 4'd9
    } outcome_t;

    typedef enum logic [2:0] {
        REG_MIN_CHILD  = 3'd0,
        REG_MIN_SIZE   = 3'd1,
        REG_MAX_SIZE   = 3'd2,
        REG_THRESHOLD  = 3'd3,
        REG_WINDOW     = 3'd4,
        REG_MARGIN     = 3'd5,
        REG_HOLD       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] min_child_count;
        logic [47:0] min_file_size;
        logic [47:0] max_file_size;
        logic [7:0]  open_threshold;
        logic [15:0] open_window;
        logic [15:0] creation_margin;
        logic [15:0] cache_hold_time;
    } cfg_t;

endpackage

[hdl/dort_regs.sv]
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
module dort_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output dort_pkg::cfg_t      cfg
);

    dort_pkg::cfg_t   cfg_reg;
    dort_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = dort_pkg::reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_child_count <= 32'd20;
            cfg_reg.min_file_size   <= 48'd2097152;
            cfg_reg.max_file_size   <= 48'd104857600;
            cfg_reg.open_threshold  <= 8'd8;
            cfg_reg.open_window     <= 16'd2;
            cfg_reg.creation_margin <= 16'd5;
            cfg_reg.cache_hold_time <= 16'd7200;
        end else if (wr_en) begin
            case (idx)
                dort_pkg::REG_MIN_CHILD: cfg_reg.min_child_count <= pwdata[31:0];
                dort_pkg::REG_MIN_SIZE:  cfg_reg.min_file_size   <= pwdata[47:0];
                dort_pkg::REG_MAX_SIZE:  cfg_reg.max_file_size   <= pwdata[47:0];
                dort_pkg::REG_THRESHOLD: cfg_reg.open_threshold  <= pwdata[7:0];
                dort_pkg::REG_WINDOW:    cfg_reg.open_window     <= pwdata[15:0];
                dort_pkg::REG_MARGIN:    cfg_reg.creation_margin <= pwdata[15:0];
                dort_pkg::REG_HOLD:      cfg_reg.cache_hold_time <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dort_pkg::REG_MIN_CHILD: prdata = {32'd0, cfg_reg.min_child_count};
            dort_pkg::REG_MIN_SIZE:  prdata = {16'd0, cfg_reg.min_file_size};
            dort_pkg::REG_MAX_SIZE:  prdata = {16'd0, cfg_reg.max_file_size};
            dort_pkg::REG_THRESHOLD: prdata = {56'd0, cfg_reg.open_threshold};
            dort_pkg::REG_WINDOW:    prdata = {48'd0, cfg_reg.open_window};
            dort_pkg::REG_MARGIN:    prdata = {48'd0, cfg_reg.creation_margin};
            dort_pkg::REG_HOLD:      prdata = {48'd0, cfg_reg.cache_hold_time};
            default:                 prdata = 64'd0;
        endcase
    end

endmodule

[hdl/directory_open_rate_tracker.sv]
// Top level of the directory open rate tracker: filters, LRU table and result register.
`timescale 1ns / 1ps
`include "directory_open_rate_tracker_macros.svh"
// Usage notes.
// The slave stream carries one file-open event per transfer. The event is
// registered, then filtered and looked up in a 64-entry LRU table held in
// flip-flops; all keys are compared in parallel and the ages of all slots are
// updated in the same cycle. The master stream returns one result per event.
// m_tvalid is driven by the result register, which is loaded from the input
// register once any earlier result has been taken. The block takes one event
// per cycle while the receiver does not stall; each event sees the table as
// the previous one left it.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; s_tready then drops until the result is taken.
// A synchronous low aresetn empties the table, clears the hit, miss and
// eviction counters and loads the configuration defaults; there is no
// clearing pass, so events are taken from the first cycle after reset.
// Configuration must be written over the APB-style port only while no event is in
// flight; the block does not enforce this. Registers are 8 bytes apart.
module directory_open_rate_tracker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // key_high[63:0], key_low[127:64], child_count[159:128],
    // file_size[207:160], creation_time[239:208], now_time[271:240]
    input  logic [271:0]  s_tdata,
    // dir_known[0]
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // entry_state[1:0], evicted[2], hit_total[34:3], miss_total[66:35],
    // evict_total[98:67], zero fill [103:99]
    output logic [103:0]  m_tdata,
    // outcome[3:0]
    output logic [3:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam int N  = dort_pkg::TABLE_ENTRIES;
    localparam int IW = dort_pkg::IDX_W;
    localparam int UW = dort_pkg::USED_W;

    dort_pkg::cfg_t cfg;

    dort_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    logic         in_valid_reg;
    logic [271:0] in_data_reg;
    logic         in_known_reg;

    // Result register.
    logic         out_valid_reg;
    logic [103:0] out_data_reg;
    logic [3:0]   out_outcome_reg;

    // Table.
    logic [N-1:0]          valid_reg;
    logic [63:0]           key_hi_reg [N];
    logic [63:0]           key_lo_reg [N];
    logic [1:0]            phase_reg  [N];
    logic [32:0]           dline_reg  [N];
    logic [7:0]            opens_reg  [N];
    logic [IW-1:0]         rec_reg    [N];
    logic [UW-1:0]         used_reg;
    logic [31:0]           hits_reg, misses_reg, evicts_reg;

    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Unpacked event fields.
    logic [63:0] kh, kl;
    logic [31:0] children, cr_time, now;
    logic [47:0] fsize;
    assign kh       = in_data_reg[63:0];
    assign kl       = in_data_reg[127:64];
    assign children = in_data_reg[159:128];
    assign fsize    = in_data_reg[207:160];
    assign cr_time  = in_data_reg[239:208];
    assign now      = in_data_reg[271:240];

    logic [32:0] now_margin;
    assign now_margin = {1'b0, now} + {17'd0, cfg.creation_margin};

    // Lookup and slot selection.
    logic          hit;
    logic [IW-1:0] hit_idx, free_idx, victim_idx, ins_idx;
    logic          table_full;
    logic [1:0]    h_phase;
    logic [32:0]   h_dline;
    logic [7:0]    h_opens;
    logic [IW-1:0] h_rec;

    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_hi_reg[i] == kh && key_lo_reg[i] == kl) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
            end
            if (valid_reg[i] && rec_reg[i] == IW'(N - 1)) begin
                victim_idx = IW'(i);
            end
        end
    end

    assign table_full = (used_reg == UW'(N));
    assign ins_idx    = table_full ? victim_idx : free_idx;
    assign h_phase    = phase_reg[hit_idx];
    assign h_dline    = dline_reg[hit_idx];
    assign h_opens    = opens_reg[hit_idx];
    assign h_rec      = rec_reg[hit_idx];

    // Filters and phase machine of the hit entry.
    dort_pkg::outcome_t outcome;
    logic               pass;
    logic [1:0]         new_phase;
    logic [32:0]        new_dline;
    logic [7:0]         new_opens, opens_inc;

    assign opens_inc = (h_opens == 8'hFF) ? h_opens : h_opens + 8'd1;

    always_comb begin
        pass      = 1'b0;
        new_phase = h_phase;
        new_dline = h_dline;
        new_opens = h_opens;
        outcome   = dort_pkg::OC_UNKNOWN;
        if (!in_known_reg) begin
            outcome = dort_pkg::OC_UNKNOWN;
        end else if (children < cfg.min_child_count) begin
            outcome = dort_pkg::OC_FEW;
        end else if (fsize < cfg.min_file_size || fsize > cfg.max_file_size) begin
            outcome = dort_pkg::OC_SIZE;
        end else if ({1'b0, cr_time} >= now_margin) begin
            outcome = dort_pkg::OC_TOO_NEW;
        end else begin
            pass = 1'b1;
            if (!hit) begin
                outcome = dort_pkg::OC_INSERTED;
            end else begin
                case (h_phase)
                    dort_pkg::PH_IDLE: begin
                        new_dline = {1'b0, now} + {17'd0, cfg.open_window};
                        new_opens = 8'd0;
                        new_phase = dort_pkg::PH_PREP;
                        outcome   = dort_pkg::OC_PREPARE;
                    end
                    dort_pkg::PH_PREP: begin
                        new_opens = opens_inc;
                        if ({1'b0, now} < h_dline) begin
                            outcome = dort_pkg::OC_COUNTING;
                        end else if (opens_inc < cfg.open_threshold) begin
                            new_phase = dort_pkg::PH_IDLE;
                            outcome   = dort_pkg::OC_IDLE;
                        end else begin
                            new_dline = {1'b0, now} + {17'd0, cfg.cache_hold_time};
                            new_phase = dort_pkg::PH_CACHED;
                            outcome   = dort_pkg::OC_CACHED;
                        end
                    end
                    default: begin
                        // Cached, and the never-stored code three, rearm.
                        new_dline = {1'b0, now} + {17'd0, cfg.cache_hold_time};
                        new_phase = dort_pkg::PH_CACHED;
                        outcome   = dort_pkg::OC_REARMED;
                    end
                endcase
            end
        end
    end

    logic        do_miss, do_hit, do_evict;
    logic [31:0] hits_next, misses_next, evicts_next;
    logic [UW-1:0] used_next;
    logic [1:0]  state_out;

    assign do_miss     = advance && pass && !hit;
    assign do_hit      = advance && pass && hit;
    assign do_evict    = do_miss && table_full;
    assign hits_next   = do_hit ? hits_reg + 32'd1 : hits_reg;
    assign misses_next = do_miss ? misses_reg + 32'd1 : misses_reg;
    assign evicts_next = do_evict ? evicts_reg + 32'd1 : evicts_reg;
    assign used_next   = (do_miss && !table_full) ? used_reg + UW'(1) : used_reg;
    assign state_out   = (pass && hit) ? new_phase : dort_pkg::PH_IDLE;

    // Control, counters and stream registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            used_reg      <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_miss) begin
                valid_reg[ins_idx] <= 1'b1;
            end
            used_reg   <= used_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
        end
    end

    // Payload registers and table contents.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_known_reg <= s_tuser;
        end
        if (advance) begin
            out_outcome_reg <= outcome;
            out_data_reg    <= {5'd0, evicts_next, misses_next, hits_next,
                                do_evict, state_out};
        end
        for (int i = 0; i < N; i++) begin
            if (do_miss) begin
                if (IW'(i) == ins_idx) begin
                    rec_reg[i] <= '0;
                end else if (valid_reg[i]) begin
                    rec_reg[i] <= rec_reg[i] + IW'(1);
                end
            end else if (do_hit) begin
                if (IW'(i) == hit_idx) begin
                    rec_reg[i] <= '0;
                end else if (valid_reg[i] && rec_reg[i] < h_rec) begin
                    rec_reg[i] <= rec_reg[i] + IW'(1);
                end
            end
        end
        if (do_miss) begin
            key_hi_reg[ins_idx] <= kh;
            key_lo_reg[ins_idx] <= kl;
            phase_reg[ins_idx]  <= dort_pkg::PH_IDLE;
            dline_reg[ins_idx]  <= '0;
            opens_reg[ins_idx]  <= '0;
        end else if (do_hit) begin
            phase_reg[hit_idx] <= new_phase;
            dline_reg[hit_idx] <= new_dline;
            opens_reg[hit_idx] <= new_opens;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_outcome_reg;

    // The fill count follows the valid bits exactly.
    `DORT_ASSERT_ALWAYS(a_used_matches, aclk, aresetn, $countones(valid_reg) == 32'(used_reg))
    // An eviction only happens on an insert into a full table.
    `DORT_ASSERT_IMPL(a_evict_full, aclk, aresetn, do_evict, do_miss && table_full)
    // A reported eviction always belongs to an inserted result.
    `DORT_ASSERT_IMPL(a_evict_outcome, aclk, aresetn, m_tvalid && m_tdata[2], m_tuser == dort_pkg::OC_INSERTED)

endmodule

[dv/dort_checker.sv]
// Checker for the directory open rate tracker: predicts each result and compares it.
`timescale 1ns / 1ps
module dort_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [271:0]  s_tdata,
    input  logic          s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [103:0]  m_tdata,
    input  logic [3:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    input  logic          pready,
    output int            fail_count,
    output int            outstanding,
    output int            result_count
);

    typedef struct packed {
        dort_pkg::outcome_t outcome;
        dort_pkg::phase_t   phase;
        logic               evicted;
        logic [31:0]        hits;
        logic [31:0]        misses;
        logic [31:0]        evicts;
    } open_result_t;

    dort_pkg::cfg_t   cfg;
    logic             dir_valid [dort_pkg::TABLE_ENTRIES];
    logic [63:0]      dir_key_hi [dort_pkg::TABLE_ENTRIES];
    logic [63:0]      dir_key_lo [dort_pkg::TABLE_ENTRIES];
    dort_pkg::phase_t dir_phase [dort_pkg::TABLE_ENTRIES];
    logic [32:0]      dir_deadline [dort_pkg::TABLE_ENTRIES];
    logic [7:0]       dir_opens [dort_pkg::TABLE_ENTRIES];
    int               dir_age [dort_pkg::TABLE_ENTRIES];
    int               dirs_used;
    logic [31:0]      hit_cnt, miss_cnt, evict_cnt;
    open_result_t     pending_results [$];

    // Works out the result of one open event and updates the directory table.
    task automatic track_open(input logic [271:0] d, input logic known,
                              output open_result_t r);
        logic [63:0] kh, kl;
        logic [31:0] children, created, now;
        logic [47:0] fsize;
        int          slot, oldest;
        logic        found;
        kh = d[63:0];
        kl = d[127:64];
        children = d[159:128];
        fsize = d[207:160];
        created = d[239:208];
        now = d[271:240];
        slot = 0;
        oldest = -1;
        found = 1'b0;
        r = '0;
        if (!known) begin
            r.outcome = dort_pkg::OC_UNKNOWN;
        end else if (children < cfg.min_child_count) begin
            r.outcome = dort_pkg::OC_FEW;
        end else if (fsize < cfg.min_file_size || fsize > cfg.max_file_size) begin
            r.outcome = dort_pkg::OC_SIZE;
        end else if ({1'b0, created} >= {1'b0, now} + {17'd0, cfg.creation_margin}) begin
            r.outcome = dort_pkg::OC_TOO_NEW;
        end else begin
            for (int i = 0; i < dort_pkg::TABLE_ENTRIES; i++)
                if (!found && dir_valid[i] && dir_key_hi[i] == kh && dir_key_lo[i] == kl) begin
                    slot = i;
                    found = 1'b1;
                end
            if (!found) begin
                // Miss: take the first free slot, or evict the least recent one.
                miss_cnt++;
                if (dirs_used < dort_pkg::TABLE_ENTRIES) begin
                    for (int i = dort_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!dir_valid[i]) slot = i;
                end else begin
                    for (int i = 0; i < dort_pkg::TABLE_ENTRIES; i++)
                        if (dir_valid[i] && dir_age[i] >= oldest) begin
                            oldest = dir_age[i];
                            slot = i;
                        end
                    dir_valid[slot] = 1'b0;
                    dirs_used--;
                    evict_cnt++;
                    r.evicted = 1'b1;
                end
                for (int i = 0; i < dort_pkg::TABLE_ENTRIES; i++)
                    if (dir_valid[i]) dir_age[i]++;
                dir_valid[slot] = 1'b1;
                dir_key_hi[slot] = kh;
                dir_key_lo[slot] = kl;
                dir_phase[slot] = dort_pkg::PH_IDLE;
                dir_deadline[slot] = '0;
                dir_opens[slot] = '0;
                dir_age[slot] = 0;
                dirs_used++;
                r.outcome = dort_pkg::OC_INSERTED;
                r.phase = dort_pkg::PH_IDLE;
            end else begin
                hit_cnt++;
                for (int i = 0; i < dort_pkg::TABLE_ENTRIES; i++)
                    if (dir_valid[i] && i != slot && dir_age[i] < dir_age[slot]) dir_age[i]++;
                dir_age[slot] = 0;
                if (dir_phase[slot] == dort_pkg::PH_IDLE) begin
                    dir_deadline[slot] = {1'b0, now} + {17'd0, cfg.open_window};
                    dir_opens[slot] = '0;
                    dir_phase[slot] = dort_pkg::PH_PREP;
                    r.outcome = dort_pkg::OC_PREPARE;
                end else if (dir_phase[slot] == dort_pkg::PH_PREP) begin
                    if (dir_opens[slot] != 8'hFF) dir_opens[slot]++;
                    if ({1'b0, now} < dir_deadline[slot]) begin
                        r.outcome = dort_pkg::OC_COUNTING;
                    end else if (dir_opens[slot] < cfg.open_threshold) begin
                        dir_phase[slot] = dort_pkg::PH_IDLE;
                        r.outcome = dort_pkg::OC_IDLE;
                    end else begin
                        dir_deadline[slot] = {1'b0, now} + {17'd0, cfg.cache_hold_time};
                        dir_phase[slot] = dort_pkg::PH_CACHED;
                        r.outcome = dort_pkg::OC_CACHED;
                    end
                end else begin
                    dir_deadline[slot] = {1'b0, now} + {17'd0, cfg.cache_hold_time};
                    dir_phase[slot] = dort_pkg::PH_CACHED;
                    r.outcome = dort_pkg::OC_REARMED;
                end
                r.phase = dir_phase[slot];
            end
        end
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
    endtask

    always @(posedge aclk) begin
        open_result_t want, got;
        if (!aresetn) begin
            cfg.min_child_count = 32'd20;
            cfg.min_file_size = 48'd2097152;
            cfg.max_file_size = 48'd104857600;
            cfg.open_threshold = 8'd8;
            cfg.open_window = 16'd2;
            cfg.creation_margin = 16'd5;
            cfg.cache_hold_time = 16'd7200;
            for (int i = 0; i < dort_pkg::TABLE_ENTRIES; i++) dir_valid[i] = 1'b0;
            dirs_used = 0;
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
            pending_results.delete();
            fail_count = 0;
            result_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (dort_pkg::reg_idx_t'(paddr[5:3]))
                    dort_pkg::REG_MIN_CHILD: cfg.min_child_count = pwdata[31:0];
                    dort_pkg::REG_MIN_SIZE:  cfg.min_file_size = pwdata[47:0];
                    dort_pkg::REG_MAX_SIZE:  cfg.max_file_size = pwdata[47:0];
                    dort_pkg::REG_THRESHOLD: cfg.open_threshold = pwdata[7:0];
                    dort_pkg::REG_WINDOW:    cfg.open_window = pwdata[15:0];
                    dort_pkg::REG_MARGIN:    cfg.creation_margin = pwdata[15:0];
                    dort_pkg::REG_HOLD:      cfg.cache_hold_time = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                track_open(s_tdata, s_tuser, want);
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                got.outcome = dort_pkg::outcome_t'(m_tuser);
                got.phase = dort_pkg::phase_t'(m_tdata[1:0]);
                got.evicted = m_tdata[2];
                got.hits = m_tdata[34:3];
                got.misses = m_tdata[66:35];
                got.evicts = m_tdata[98:67];
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with none expected, actual %h", $time, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want || m_tdata[103:99] !== 5'd0) begin
                        fail_count++;
                        $display("%0t: mismatch expected oc=%0d ph=%0d ev=%0b h=%0d m=%0d e=%0d",
                                 $time, want.outcome, want.phase, want.evicted, want.hits,
                                 want.misses, want.evicts);
                        $display("%0t:          actual oc=%0d ph=%0d ev=%0b h=%0d m=%0d e=%0d",
                                 $time, got.outcome, got.phase, got.evicted, got.hits,
                                 got.misses, got.evicts);
                    end
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

[dv/tb.sv]
// Testbench top for the directory open rate tracker: stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    // key_high[63:0], key_low[127:64], child_count[159:128],
    // file_size[207:160], creation_time[239:208], now_time[271:240]
    logic [271:0]  s_tdata;
    // dir_known[0]
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    // entry_state[1:0], evicted[2], hit_total[34:3], miss_total[66:35],
    // evict_total[98:67], zero fill [103:99]
    logic [103:0]  m_tdata;
    // outcome[3:0]
    logic [3:0]    m_tuser;
    logic          psel, penable, pwrite;
    logic [5:0]    paddr;
    logic [63:0]   pwdata;
    logic [63:0]   prdata;
    logic          pready;
    int            fail_count, outstanding, result_count;

    // Stimulus-side copy of the settings, used only to shape events that pass
    // the filters; the checker keeps its own copy from the bus writes.
    logic [31:0]   child_floor;
    logic [47:0]   size_lo, size_hi;
    logic [15:0]   margin;
    logic [31:0]   clock_now;
    logic [127:0]  dir_pool [100];
    int            pool_size;
    int            events_sent;
    int            burst_left;
    logic          long_hold_done;

    directory_open_rate_tracker i_dut (.*);

    dort_checker i_checker (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Receiver: alternates stretches of full readiness with random stalls, and
    // once holds off for a long stretch so the block backs up into its input.
    initial begin
        int mode_cycles;
        logic stall_mode;
        m_tready = 1'b0;
        long_hold_done = 1'b0;
        mode_cycles = 0;
        stall_mode = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && events_sent >= 400) begin
                m_tready = 1'b0;
                repeat (150) @(negedge aclk);
                long_hold_done = 1'b1;
            end
            if (mode_cycles == 0) begin
                mode_cycles = $urandom_range(10, 80);
                stall_mode = $urandom_range(0, 1);
            end
            mode_cycles--;
            m_tready = stall_mode ? ($urandom_range(0, 99) < 60) : 1'b1;
        end
    end

    task automatic cfg_write(input dort_pkg::reg_idx_t idx, input logic [63:0] value);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits for every outstanding result, plus the pipeline depth, so that the
    // configuration is only touched while the block is idle.
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [31:0] mc, input logic [47:0] lo,
                                  input logic [47:0] hi, input logic [7:0] thr,
                                  input logic [15:0] win, input logic [15:0] mg,
                                  input logic [15:0] hold);
        drain();
        cfg_write(dort_pkg::REG_MIN_CHILD, {32'd0, mc});
        cfg_write(dort_pkg::REG_MIN_SIZE, {16'd0, lo});
        cfg_write(dort_pkg::REG_MAX_SIZE, {16'd0, hi});
        cfg_write(dort_pkg::REG_THRESHOLD, {56'd0, thr});
        cfg_write(dort_pkg::REG_WINDOW, {48'd0, win});
        cfg_write(dort_pkg::REG_MARGIN, {48'd0, mg});
        cfg_write(dort_pkg::REG_HOLD, {48'd0, hold});
        child_floor = mc;
        size_lo = lo;
        size_hi = hi;
        margin = mg;
    endtask

    // Offers one event and returns once its transfer has happened. Valid stays
    // high into the next event unless a gap between bursts is due.
    task automatic offer_event(input logic [127:0] key, input logic known,
                               input logic [31:0] children, input logic [47:0] fsize,
                               input logic [31:0] created, input logic [31:0] now,
                               input logic gaps);
        @(negedge aclk);
        s_tdata = {now, created, fsize, children, key};
        s_tuser = known;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Builds an event meant to pass every filter, for the key and time given.
    task automatic offer_passing(input logic [127:0] key, input logic [31:0] now);
        logic [32:0] span, newest;
        logic [31:0] children, created;
        logic [47:0] fsize;
        span = 33'h1_0000_0000 - {1'b0, child_floor};
        children = child_floor + 32'({$urandom} % span);
        if (size_hi >= size_lo) fsize = size_lo + 48'({$urandom, $urandom} % (size_hi - size_lo + 49'd1));
        else fsize = size_lo;
        newest = {1'b0, now} + {17'd0, margin};
        if (newest == 0) begin
            created = $urandom;
        end else begin
            newest = newest - 33'd1;
            if (newest > 33'hFFFF_FFFF) newest = 33'hFFFF_FFFF;
            created = newest[31:0] - (newest[31:0] > 1000 ? 32'($urandom_range(0, 1000))
                                                            : 32'd0);
            if ($urandom_range(0, 3) == 0 && newest[31:0] != 0)
                created = 32'({$urandom} % {1'b0, newest[31:0]});
        end
        offer_event(key, 1'b1, children, fsize, created, now, 1'b1);
    endtask

    task automatic fill_pool;
        for (int i = 0; i < 100; i++) dir_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    endtask

    // One stretch of random traffic: mostly well-formed opens on a key pool,
    // the rest raw noise that mostly trips the filters.
    task automatic random_traffic(input int count);
        logic [127:0] key;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 80) begin
                key = dir_pool[$urandom_range(0, pool_size - 1)];
                if ($urandom_range(0, 99) < 60) clock_now = clock_now + 32'($urandom_range(0, 1));
                else if ($urandom_range(0, 99) < 5) clock_now = clock_now + $urandom_range(0, 70000);
                offer_passing(key, clock_now);
            end else begin
                offer_event({$urandom, $urandom, $urandom, $urandom}, $urandom_range(0, 1),
                            $urandom, {$urandom, $urandom}, $urandom, $urandom, 1'b1);
            end
        end
    endtask

    initial begin
        logic [127:0] key_a, key_b;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        events_sent = 0;
        burst_left = 0;
        child_floor = 32'd20;
        size_lo = 48'd2097152;
        size_hi = 48'd104857600;
        margin = 16'd5;
        clock_now = 32'd100;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset defaults: every filter, then a key
        // walked through insert, prepare, counting, cached and rearm.
        key_a = '1;
        key_b = '0;
        offer_event(key_a, 1'b0, 32'd50, 48'd3000000, 32'd0, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd19, 48'd3000000, 32'd0, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd2097151, 32'd0, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd104857601, 32'd0, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd2097152, 32'd105, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, '1, 48'd104857600, 32'd104, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd100, 1'b0);
        for (int i = 0; i < 7; i++)
            offer_event(key_a, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd100, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd102, 1'b0);
        offer_event(key_a, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd103, 1'b0);
        offer_event(key_b, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd200, 1'b0);
        offer_event(key_b, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd200, 1'b0);
        offer_event(key_b, 1'b1, 32'd20, 48'd2097152, 32'd0, 32'd500, 1'b0);
        // Time at its top: creation at the very end still passes with a margin.
        offer_event(key_b, 1'b1, 32'd20, 48'd2097152, '1, '1, 1'b0);
        offer_event(key_b, 1'b1, 32'd20, 48'd2097152, '1, '1, 1'b0);

        // The sender pauses here until every result is back.
        drain();
        fill_pool();
        pool_size = 8;
        random_traffic(350);

        // Loosest child and size filters, no creation margin, short window and hold,
        // and a pool that overflows the table to force evictions.
        apply_settings(32'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 8'd2, 16'd3, 16'd0, 16'd5);
        fill_pool();
        pool_size = 100;
        random_traffic(350);

        // Extremes: tightest child, size and threshold settings, widest margin, window and hold.
        apply_settings(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd255,
                       16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill_pool();
        pool_size = 6;
        random_traffic(250);

        // Narrow size window, zero window and hold, threshold of one.
        apply_settings(32'd100, 48'd1000, 48'd5000, 8'd1, 16'd0, 16'd10, 16'd0);
        fill_pool();
        pool_size = 12;
        random_traffic(300);

        // Random settings with an empty size window allowed, threshold zero.
        apply_settings($urandom_range(0, 5000), 48'($urandom_range(0, 4000)),
                       48'($urandom_range(0, 4000)), 8'd0, 16'($urandom_range(0, 8)),
                       16'($urandom), 16'($urandom));
        fill_pool();
        pool_size = 70;
        random_traffic(380);

        drain();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d events and %0d results over five settings,", events_sent,
                 result_count);
        $display("including filter extremes, LRU evictions and the full phase cycle.");
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
